FILE: src/mlpp_pkg.sv
// ---------------------------------------------------------------------------
// mlpp_pkg: shared types and constants for the priority mutex core
// Field layouts, request and status codes, sizing and width helpers.
// ---------------------------------------------------------------------------
package mlpp_pkg;

  // Sizing of the internal state
  localparam int THREAD_ID_BITS = 8;
  localparam int PRIO_BITS      = 8;
  localparam int COUNT_BITS     = 16;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [THREAD_ID_BITS-1:0] id_t;
  typedef logic [PRIO_BITS-1:0]      prio_t;
  typedef logic [COUNT_BITS-1:0]     cnt_t;

  // Request kinds
  localparam logic [1:0] KIND_LOCK   = 2'd0;
  localparam logic [1:0] KIND_UNLOCK = 2'd1;
  localparam logic [1:0] KIND_RESET  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LIMIT    = 3'd1;
  localparam logic [2:0] ST_DEADLOCK = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_PERM     = 3'd4;
  localparam logic [2:0] ST_NOTREC   = 3'd5;

  // Wake codes
  localparam logic [1:0] WAKE_NONE = 2'd0;
  localparam logic [1:0] WAKE_ONE  = 2'd1;
  localparam logic [1:0] WAKE_ALL  = 2'd2;

  // Mutex types and priority protocols
  localparam logic [1:0] TYPE_NORMAL     = 2'd0;
  localparam logic [1:0] TYPE_ERRORCHECK = 2'd1;
  localparam logic [1:0] TYPE_RECURSIVE  = 2'd2;
  localparam logic [1:0] PROTO_NONE      = 2'd0;
  localparam logic [1:0] PROTO_INHERIT   = 2'd1;
  localparam logic [1:0] PROTO_PROTECT   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MUTEX_TYPE = 3'd0;
  localparam logic [2:0] CFG_PROTOCOL   = 3'd1;
  localparam logic [2:0] CFG_ROBUST     = 3'd2;
  localparam logic [2:0] CFG_MAX_RECUR  = 3'd3;
  localparam logic [2:0] CFG_CEILING    = 3'd4;

  localparam logic [15:0] MAX_RECUR_RESET = 16'hffff;

  // Port payloads
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] thread_id;
    logic [7:0] thread_prio;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       prio_update;
    logic [7:0] prio_target;
    logic [7:0] prio_value;
    logic [1:0] wake;
  } rsp_t;

  // Configuration bundle
  typedef struct packed {
    logic [1:0]  mutex_type;
    logic [1:0]  priority_protocol;
    logic        robust_mode;
    logic [15:0] max_recursion;
    logic [7:0]  ceiling_priority;
  } cfg_t;

  // Classified request held in the queue
  typedef enum logic [1:0] {
    OP_LOCK,
    OP_UNLOCK,
    OP_RESET,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t   op;
    id_t   tid;
    prio_t prio;
  } job_t;

  // Queue handshake bundles
  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qsts_t;

  // Width conversion between 8-bit fields and internal widths
  function automatic id_t field_to_id(logic [7:0] x);
    logic [15:0] w;
    w = 16'(x);
    return w[THREAD_ID_BITS-1:0];
  endfunction

  function automatic prio_t field_to_prio(logic [7:0] x);
    logic [15:0] w;
    w = 16'(x);
    return w[PRIO_BITS-1:0];
  endfunction

  function automatic logic [7:0] id_to_field(id_t x);
    logic [15:0] w;
    w = 16'(x);
    return w[7:0];
  endfunction

  function automatic logic [7:0] prio_to_field(prio_t x);
    logic [15:0] w;
    w = 16'(x);
    return w[7:0];
  endfunction

endpackage

FILE: src/mlpp_front.sv
// ---------------------------------------------------------------------------
// mlpp_front: request intake
// Accepts requests, decodes the kind and trims ids and priorities.
// ---------------------------------------------------------------------------
module mlpp_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  mlpp_pkg::req_t req,
  input  mlpp_pkg::qsts_t qsts,
  output logic          push,
  output mlpp_pkg::job_t push_job
);
  import mlpp_pkg::*;

  // Stall while the queue has no room
  assign req_stall = qsts.full;
  assign push      = req_valid & ~qsts.full;

  // Classify the request
  always_comb begin
    push_job.tid  = field_to_id(req.thread_id);
    push_job.prio = field_to_prio(req.thread_prio);
    case (req.kind)
      KIND_LOCK:   push_job.op = OP_LOCK;
      KIND_UNLOCK: push_job.op = OP_UNLOCK;
      KIND_RESET:  push_job.op = OP_RESET;
      default:     push_job.op = OP_BAD;
    endcase
  end

endmodule

FILE: src/mlpp_queue.sv
// ---------------------------------------------------------------------------
// mlpp_queue: short request queue
// Decouples the intake from the executing back end.
// ---------------------------------------------------------------------------
module mlpp_queue (
  input  logic            clk,
  input  logic            rst,
  input  mlpp_pkg::qctl_t qctl,
  input  mlpp_pkg::job_t  push_job,
  output mlpp_pkg::qsts_t qsts,
  output mlpp_pkg::job_t  head
);
  import mlpp_pkg::*;

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign qsts.full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign qsts.nonempty = (count != '0);
  assign do_push       = qctl.push & ~qsts.full;
  assign do_pop        = qctl.pop & qsts.nonempty;
  assign head          = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on transfer out");
  a_push_follows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on transfer in");
`endif

endmodule

FILE: src/mlpp_back.sv
// ---------------------------------------------------------------------------
// mlpp_back: mutex execution
// Holds owner state, applies the type and protocol rules, registers results.
// ---------------------------------------------------------------------------
module mlpp_back (
  input  logic           clk,
  input  logic           rst,
  input  mlpp_pkg::cfg_t cfg,
  input  logic           job_valid,
  input  mlpp_pkg::job_t job,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mlpp_pkg::rsp_t rsp
);
  import mlpp_pkg::*;

  logic  locked;
  id_t   owner_id;
  cnt_t  lock_count;
  prio_t saved_prio;
  prio_t owner_cur_prio;

  logic  locked_next;
  id_t   owner_id_next;
  cnt_t  lock_count_next;
  prio_t saved_prio_next;
  prio_t owner_cur_prio_next;
  rsp_t  rsp_next;

  logic  recursive;
  logic  errcheck;
  logic  inherit;
  logic  protect;
  logic  is_owner;
  prio_t ceil;

  // Take the next job when the output register is free or draining
  assign pop = job_valid & (~rsp_valid | ~rsp_stall);

  assign recursive = (cfg.mutex_type == TYPE_RECURSIVE);
  assign errcheck  = (cfg.mutex_type == TYPE_ERRORCHECK);
  assign inherit   = (cfg.priority_protocol == PROTO_INHERIT);
  assign protect   = (cfg.priority_protocol == PROTO_PROTECT);
  assign is_owner  = (owner_id == job.tid);
  assign ceil      = field_to_prio(cfg.ceiling_priority);

  // Request execution
  always_comb begin
    locked_next         = locked;
    owner_id_next       = owner_id;
    lock_count_next     = lock_count;
    saved_prio_next     = saved_prio;
    owner_cur_prio_next = owner_cur_prio;
    rsp_next            = '0;
    rsp_next.status     = ST_OK;
    rsp_next.wake       = WAKE_NONE;
    case (job.op)
      OP_LOCK: begin
        if (!locked) begin
          locked_next         = 1'b1;
          owner_id_next       = job.tid;
          lock_count_next     = cnt_t'(1);
          owner_cur_prio_next = job.prio;
          if (inherit || protect) begin
            saved_prio_next = job.prio;
          end
          if (protect && (ceil > job.prio)) begin
            rsp_next.prio_update = 1'b1;
            rsp_next.prio_target = id_to_field(job.tid);
            rsp_next.prio_value  = prio_to_field(ceil);
            owner_cur_prio_next  = ceil;
          end
        end else if (is_owner && recursive) begin
          if ((32'(lock_count) >= 32'(cfg.max_recursion)) || (lock_count == '1)) begin
            rsp_next.status = ST_LIMIT;
          end else begin
            lock_count_next = lock_count + 1'b1;
          end
        end else if (is_owner && errcheck) begin
          rsp_next.status = ST_DEADLOCK;
        end else begin
          // Held elsewhere, or relocked by the owner of a normal mutex: boost the owner under inheritance
          if (inherit && (job.prio > owner_cur_prio)) begin
            rsp_next.prio_update = 1'b1;
            rsp_next.prio_target = id_to_field(owner_id);
            rsp_next.prio_value  = prio_to_field(job.prio);
            owner_cur_prio_next  = job.prio;
          end
          rsp_next.status = ST_BUSY;
        end
      end
      OP_UNLOCK: begin
        if (locked && is_owner) begin
          if (recursive && (lock_count > cnt_t'(1))) begin
            lock_count_next = lock_count - 1'b1;
          end else begin
            if (inherit || protect) begin
              rsp_next.prio_update = 1'b1;
              rsp_next.prio_target = id_to_field(owner_id);
              rsp_next.prio_value  = prio_to_field(saved_prio);
            end
            rsp_next.wake       = WAKE_ONE;
            locked_next         = 1'b0;
            owner_id_next       = '0;
            lock_count_next     = '0;
            owner_cur_prio_next = '0;
          end
        end else if (errcheck || recursive || cfg.robust_mode) begin
          rsp_next.status = ST_PERM;
        end else begin
          rsp_next.status = ST_NOTREC;
        end
      end
      OP_RESET: begin
        locked_next     = 1'b0;
        owner_id_next   = '0;
        lock_count_next = '0;
        rsp_next.wake   = WAKE_ALL;
      end
      default: begin
        rsp_next.status = ST_PERM;
      end
    endcase
  end

  // Mutex state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      locked         <= 1'b0;
      owner_id       <= '0;
      lock_count     <= '0;
      saved_prio     <= '0;
      owner_cur_prio <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (pop) begin
        locked         <= locked_next;
        owner_id       <= owner_id_next;
        lock_count     <= lock_count_next;
        saved_prio     <= saved_prio_next;
        owner_cur_prio <= owner_cur_prio_next;
        rsp_valid      <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_tracks_lock: assert property (@(posedge clk) disable iff (rst)
    locked == (lock_count != '0))
    else $error("lock count disagrees with lock flag");
  a_free_no_owner: assert property (@(posedge clk) disable iff (rst)
    !locked |-> owner_id == '0)
    else $error("owner kept while unlocked");
  a_quiet_update: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.prio_update) |-> (rsp.prio_target == 8'd0 && rsp.prio_value == 8'd0))
    else $error("priority fields set without update");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(locked) && $stable(lock_count)))
    else $error("state moved while result stalled");
`endif

endmodule

FILE: src/mutex_lock_with_priority_protocol_core.sv
// A request transferred in is held in the queue, then executed by the back end, which registers the result.
// Throughput: one request per cycle while results are not stalled; the back end's state update sets it.
// A two-entry queue lets intake continue while a result waits to be taken.
// Reset (rst, synchronous, active high) frees the mutex, empties the queue and
// returns the configuration registers to their default values.
// ---------------------------------------------------------------------------
// mutex_lock_with_priority_protocol_core: recursive mutex with priority control
// Front end classifies requests, a queue decouples it from the executing back end.
// ---------------------------------------------------------------------------
module mutex_lock_with_priority_protocol_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mlpp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mlpp_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import mlpp_pkg::*;

  cfg_t  cfg;
  qctl_t qctl;
  qsts_t qsts;
  job_t  push_job;
  job_t  head;
  logic  push;
  logic  pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mutex_type        <= TYPE_NORMAL;
      cfg.priority_protocol <= PROTO_NONE;
      cfg.robust_mode       <= 1'b0;
      cfg.max_recursion     <= MAX_RECUR_RESET;
      cfg.ceiling_priority  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MUTEX_TYPE: cfg.mutex_type        <= cfg_data[1:0];
        CFG_PROTOCOL:   cfg.priority_protocol <= cfg_data[1:0];
        CFG_ROBUST:     cfg.robust_mode       <= cfg_data[0];
        CFG_MAX_RECUR:  cfg.max_recursion     <= cfg_data;
        CFG_CEILING:    cfg.ceiling_priority  <= cfg_data[7:0];
        default:        cfg <= cfg;
      endcase
    end
  end

  assign qctl.push = push;
  assign qctl.pop  = pop;

  mlpp_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .qsts      (qsts),
    .push      (push),
    .push_job  (push_job)
  );

  mlpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .qctl     (qctl),
    .push_job (push_job),
    .qsts     (qsts),
    .head     (head)
  );

  mlpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (qsts.nonempty),
    .job       (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
